/* src/fifo_with_priority_bump_top_assert.svh */
// ----------------------------------------------------------------------------
// fifo_with_priority_bump_top_assert.svh
// Assertion macros shared by the port checkers of the priority-bump FIFO.
// Both macros expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_PRIORITY_BUMP_TOP_ASSERT_SVH
`define FIFO_WITH_PRIORITY_BUMP_TOP_ASSERT_SVH

// same-cycle implication
`define FPB_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpb port check failed");

// next-cycle implication
`define FPB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpb port check failed");

`endif

/* src/fpb_pkg.sv */
// ----------------------------------------------------------------------------
// fpb_pkg
// Shared types, codes and field layout of the priority-bump FIFO.
// ----------------------------------------------------------------------------
package fpb_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int WORD_WIDTH_DEFAULT = 32;

    localparam int VALUE_W      = 32;
    localparam int OUT_VALUE_W  = 32;
    localparam int FILL_W       = 5;
    localparam int IN_VALUE_LSB = 2;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 40;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_RAISE   = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOMATCH  = 2'd3
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    set_status;
        status_t status;
        logic    wr_tail;
        logic    rd_head;
        logic    deq_take;
        logic    scan_start;
        logic    rd_scan;
        logic    scan_advance;
        logic    wr_ahead;
        logic    wr_here;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic scan_first;
        logic scan_last;
    } dp_stat_t;

endpackage

/* src/fpb_datapath.sv */
// ----------------------------------------------------------------------------
// fpb_datapath
// Ring storage, head/tail/count pointers, scan pointers and result registers.
// ----------------------------------------------------------------------------
module fpb_datapath #(
    parameter int DEPTH      = fpb_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = fpb_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [fpb_pkg::VALUE_W-1:0]     in_value,
    input  fpb_pkg::dp_cmd_t                cmd,
    output fpb_pkg::dp_stat_t               stat,
    output logic [fpb_pkg::OUT_VALUE_W-1:0] out_value,
    output fpb_pkg::status_t                out_status,
    output logic                            out_is_empty,
    output logic [fpb_pkg::FILL_W-1:0]      out_fill_count
);
    import fpb_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    logic [WORD_WIDTH-1:0] rdata_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] prev_data_reg;
    logic [WORD_WIDTH-1:0] result_reg;
    status_t               status_reg;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [ADDR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [ADDR_W-1:0] prev_ptr_reg, prev_ptr_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [OUT_VALUE_W-1:0] out_value_reg;
    status_t                out_status_reg;
    logic                   out_is_empty_reg;
    logic [FILL_W-1:0]      out_fill_reg;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;

    function automatic logic [ADDR_W-1:0] inc_ptr(input logic [ADDR_W-1:0] ptr);
        logic [ADDR_W-1:0] res;
        res = (ptr == LAST_ADDR) ? '0 : ptr + 1'b1;
        return res;
    endfunction

    assign mem_we    = cmd.wr_tail | cmd.wr_ahead | cmd.wr_here;
    assign mem_waddr = cmd.wr_ahead ? prev_ptr_reg : (cmd.wr_here ? scan_ptr_reg : tail_reg);
    assign mem_wdata = cmd.wr_here ? prev_data_reg : word_reg;
    assign mem_re    = cmd.rd_head | cmd.rd_scan;
    assign mem_raddr = cmd.rd_scan ? scan_ptr_reg : head_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_ptr_next = scan_ptr_reg;
        prev_ptr_next = prev_ptr_reg;
        k_next        = k_reg;
        if (cmd.wr_tail)
        begin
            tail_next  = inc_ptr(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.deq_take)
        begin
            head_next  = inc_ptr(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.scan_start)
        begin
            scan_ptr_next = head_reg;
            k_next        = '0;
        end
        else if (cmd.scan_advance)
        begin
            prev_ptr_next = scan_ptr_reg;
            scan_ptr_next = inc_ptr(scan_ptr_reg);
            k_next        = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            scan_ptr_reg <= '0;
            prev_ptr_reg <= '0;
            k_reg        <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            scan_ptr_reg <= scan_ptr_next;
            prev_ptr_reg <= prev_ptr_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            word_reg <= WORD_WIDTH'(in_value);
        end
        if (cmd.deq_take)
        begin
            result_reg <= rdata_reg;
        end
        else if (cmd.capture)
        begin
            result_reg <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        else if (cmd.capture)
        begin
            status_reg <= ST_OK;
        end
        if (cmd.scan_advance)
        begin
            prev_data_reg <= rdata_reg;
        end
        if (cmd.load_out)
        begin
            out_value_reg    <= OUT_VALUE_W'(result_reg);
            out_status_reg   <= status_reg;
            out_is_empty_reg <= (count_reg == '0);
            out_fill_reg     <= FILL_W'(count_reg);
        end
    end

    assign stat.full       = (count_reg == FULL_COUNT);
    assign stat.empty      = (count_reg == '0);
    assign stat.match      = (rdata_reg == word_reg);
    assign stat.scan_first = (k_reg == '0);
    assign stat.scan_last  = ((CNT_W'(k_reg) + 1'b1) == count_reg);

    assign out_value      = out_value_reg;
    assign out_status     = out_status_reg;
    assign out_is_empty   = out_is_empty_reg;
    assign out_fill_count = out_fill_reg;

endmodule

/* src/fpb_ctrl.sv */
// ----------------------------------------------------------------------------
// fpb_ctrl
// Sequencer for enqueue, dequeue and raise-priority requests, plus the
// output valid flag.
// ----------------------------------------------------------------------------
module fpb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fpb_pkg::action_t  in_action,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  fpb_pkg::dp_stat_t stat,
    output fpb_pkg::dp_cmd_t  cmd
);
    import fpb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_WRITE      = 9'b000000010,
        S_DEQ_RD     = 9'b000000100,
        S_DEQ_TAKE   = 9'b000001000,
        S_SCAN_RD    = 9'b000010000,
        S_SCAN_CMP   = 9'b000100000,
        S_SWAP_AHEAD = 9'b001000000,
        S_SWAP_HERE  = 9'b010000000,
        S_RESP       = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RESP;
                    case (in_action)
                        ACT_ENQUEUE:
                        begin
                            if (stat.full)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_WRITE;
                            end
                        end
                        ACT_DEQUEUE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DEQ_RD;
                            end
                        end
                        ACT_RAISE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_NOMATCH;
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.wr_tail = 1'b1;
                state_next  = S_RESP;
            end
            S_DEQ_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_DEQ_TAKE;
            end
            S_DEQ_TAKE:
            begin
                cmd.deq_take = 1'b1;
                state_next   = S_RESP;
            end
            S_SCAN_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    state_next = stat.scan_first ? S_RESP : S_SWAP_AHEAD;
                end
                else if (stat.scan_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOMATCH;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.scan_advance = 1'b1;
                    state_next       = S_SCAN_RD;
                end
            end
            S_SWAP_AHEAD:
            begin
                cmd.wr_ahead = 1'b1;
                state_next   = S_SWAP_HERE;
            end
            S_SWAP_HERE:
            begin
                cmd.wr_here = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == S_RESP) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/fifo_with_priority_bump_top.sv */
// ----------------------------------------------------------------------------
// fifo_with_priority_bump_top
// Bounded FIFO of words with enqueue, dequeue and raise-priority requests.
//
//   channel  | dir | handshake              | tdata
//   s_axis   | in  | s_axis_tvalid/tready   | action, value
//   m_axis   | out | m_axis_tvalid/tready   | out_value, status, is_empty, fill_count
//
// Enqueue writes the tail; dequeue reads the head, then takes it. A dropped
// enqueue, a dequeue or raise on an empty queue and an undefined action go
// straight to the response. Raise priority compares entries from the head,
// since the ring memory is read one entry at a time; a later match moves one up.
// One request is in flight; the next is accepted as soon as its result sits in
// the output register, even if that result is still stalled.
// Reset clears pointers and count; memory contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_with_priority_bump_top #(
    parameter int DEPTH      = fpb_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = fpb_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] action, [33:2] value, [39:34] zero
    input  logic [fpb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] out_value, [33:32] status, [34] is_empty, [39:35] fill_count
    output logic [fpb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import fpb_pkg::*;

    dp_cmd_t                cmd;
    dp_stat_t               stat;
    action_t                in_action;
    logic [VALUE_W-1:0]     in_value;
    logic [OUT_VALUE_W-1:0] out_value;
    status_t                out_status;
    logic                   out_is_empty;
    logic [FILL_W-1:0]      out_fill_count;

    assign in_action = action_t'(s_axis_tdata[$bits(action_t)-1:0]);
    assign in_value  = s_axis_tdata[IN_VALUE_LSB +: VALUE_W];

    fpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (in_action),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fpb_datapath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_value       (in_value),
        .cmd            (cmd),
        .stat           (stat),
        .out_value      (out_value),
        .out_status     (out_status),
        .out_is_empty   (out_is_empty),
        .out_fill_count (out_fill_count)
    );

    assign m_axis_tdata = {out_fill_count, out_is_empty, out_status, out_value};

endmodule

/* src/fpb_port_check.sv */
// ----------------------------------------------------------------------------
// fpb_port_check
// Port-level checks of the priority-bump FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "fifo_with_priority_bump_top_assert.svh"

module fpb_port_check #(
    parameter int DEPTH = fpb_pkg::DEPTH_DEFAULT
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fpb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import fpb_pkg::*;

    `FPB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `FPB_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FPB_ASSERT_IMPLY(a_fill_bound, m_axis_tvalid, m_axis_tdata[39:35] <= DEPTH)
    `FPB_ASSERT_IMPLY(a_empty_flag, m_axis_tvalid, m_axis_tdata[34] == (m_axis_tdata[39:35] == '0))
    `FPB_ASSERT_IMPLY(a_value_ok, m_axis_tvalid && (m_axis_tdata[31:0] != '0), m_axis_tdata[33:32] == ST_OK)

endmodule

bind fifo_with_priority_bump_top fpb_port_check #(
    .DEPTH (DEPTH)
) u_port_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority-bump FIFO. Requests go in on the slave
// stream, and a scoreboard keeps its own copy of the ring, head and count to
// predict each result. Results from the master stream are checked field by
// field in order. A directed opening covers the empty, head-match, swap and
// no-match cases. It is followed by random fill, drain and mixed runs, with
// idle and stall bursts on both streams.
// ----------------------------------------------------------------------------
module testbench;

    import fpb_pkg::*;

    localparam int RING_DEPTH   = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_ITEMS   = 100;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [FILL_W-1:0]      fill_count;
        logic                   is_empty;
        status_t                status;
        logic [OUT_VALUE_W-1:0] out_value;
    } fifo_result_t;

    class fifo_scoreboard;
        logic [VALUE_W-1:0] ring [RING_DEPTH];
        int unsigned        head;
        int unsigned        count;
        fifo_result_t       expected_q [$];
        int unsigned        errors;

        function new();
            head   = 0;
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [VALUE_W-1:0] pick_stored();
            if (count == 0)
                return $urandom;
            return ring[(head + $urandom_range(0, count - 1)) % RING_DEPTH];
        endfunction

        function void note_request(action_t act, logic [VALUE_W-1:0] val);
            fifo_result_t       r;
            int unsigned        k;
            int unsigned        here;
            int unsigned        ahead;
            logic [VALUE_W-1:0] swap_word;
            bit                 found;
            r        = '0;
            r.status = ST_OK;
            case (act)
                ACT_ENQUEUE:
                begin
                    if (count >= RING_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        ring[(head + count) % RING_DEPTH] = val;
                        count++;
                    end
                end
                ACT_DEQUEUE:
                begin
                    if (count == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.out_value = ring[head];
                        head        = (head + 1) % RING_DEPTH;
                        count--;
                    end
                end
                ACT_RAISE:
                begin
                    if (count == 0)
                        r.status = ST_NOMATCH;
                    else if (ring[head] != val)
                    begin
                        found = 1'b0;
                        for (k = 1; k < count && !found; k++)
                        begin
                            here = (head + k) % RING_DEPTH;
                            if (ring[here] == val)
                            begin
                                ahead       = (head + k - 1) % RING_DEPTH;
                                swap_word   = ring[ahead];
                                ring[ahead] = ring[here];
                                ring[here]  = swap_word;
                                found       = 1'b1;
                            end
                        end
                        r.status = found ? ST_OK : ST_NOMATCH;
                    end
                end
                default:
                begin
                end
            endcase
            r.is_empty   = (count == 0);
            r.fill_count = FILL_W'(count);
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(fifo_result_t got);
            fifo_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with no request pending: %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_value !== want.out_value)
                report($sformatf("out_value %h, predicted %h", got.out_value, want.out_value));
            if (got.status !== want.status)
                report($sformatf("status %0d, predicted %0d", got.status, want.status));
            if (got.is_empty !== want.is_empty)
                report($sformatf("is_empty %b, predicted %b", got.is_empty, want.is_empty));
            if (got.fill_count !== want.fill_count)
                report($sformatf("fill_count %0d, predicted %0d",
                                 got.fill_count, want.fill_count));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    fifo_scoreboard sb;
    bit             calm;
    bit             tx_busy;
    bit             rx_busy;
    int unsigned    rx_stall;

    logic [VALUE_W-1:0] value_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                           32'h8000_0000, 32'h5A5A_5A5A, 32'h0000_0007};

    fifo_with_priority_bump_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_request(input action_t act, input logic [VALUE_W-1:0] val);
        if (!calm && tx_busy && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tdata  <= {{(IN_TDATA_W - VALUE_W - IN_VALUE_LSB){1'b0}}, val, act};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(act, val);
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(input int unsigned mode, output bit counted);
        int unsigned        roll;
        int unsigned        enq_limit;
        int unsigned        deq_limit;
        action_t            act;
        logic [VALUE_W-1:0] val;
        roll      = $urandom_range(0, 99);
        enq_limit = (mode == 0) ? 60 : (mode == 1) ? 15 : 35;
        deq_limit = (mode == 0) ? 75 : (mode == 1) ? 70 : 65;
        if (roll < enq_limit)
            act = ACT_ENQUEUE;
        else if (roll < deq_limit)
            act = ACT_DEQUEUE;
        else if (roll < 97)
            act = ACT_RAISE;
        else
            act = ACT_NONE;
        roll = $urandom_range(0, 99);
        if (act == ACT_RAISE && roll < 60)
            val = sb.pick_stored();
        else if (roll < 80)
            val = value_pool[$urandom_range(0, 5)];
        else
            val = $urandom;
        send_request(act, val);
        counted = (act != ACT_NONE);
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ($urandom_range(0, 63) == 0)
                rx_busy = !rx_busy;
            if (rx_stall != 0)
                rx_stall--;
            else if (!calm && rx_busy && $urandom_range(0, 7) == 0)
                rx_stall = $urandom_range(1, 13);
            m_axis_tready <= (rx_stall == 0);
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned mode;
        bit          counted;
        sb            = new();
        calm          = 1'b0;
        tx_busy       = 1'b1;
        rx_busy       = 1'b1;
        rx_stall      = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(ACT_DEQUEUE, 32'h0000_0000);
        send_request(ACT_RAISE,   32'h0000_0000);
        send_request(ACT_NONE,    32'hFFFF_FFFF);
        send_request(ACT_ENQUEUE, 32'h0000_0000);
        send_request(ACT_ENQUEUE, 32'hFFFF_FFFF);
        send_request(ACT_ENQUEUE, 32'hAAAA_AAAA);
        send_request(ACT_ENQUEUE, 32'h5555_5555);
        send_request(ACT_ENQUEUE, 32'hAAAA_AAAA);
        send_request(ACT_RAISE,   32'h0000_0000);
        send_request(ACT_RAISE,   32'hAAAA_AAAA);
        send_request(ACT_RAISE,   32'h5555_5555);
        send_request(ACT_RAISE,   32'h1234_5678);
        send_request(ACT_NONE,    32'h0000_0000);
        repeat (5) send_request(ACT_DEQUEUE, 32'hFFFF_FFFF);
        send_request(ACT_DEQUEUE, 32'h0000_0000);
        send_request(ACT_ENQUEUE, 32'h0000_0001);
        send_request(ACT_RAISE,   32'h0000_0001);
        send_request(ACT_DEQUEUE, 32'h0000_0000);

        mode = 0;
        n    = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n % 40 == 0)
                mode = $urandom_range(0, 2);
            if (n % 60 == 0)
                tx_busy = $urandom_range(0, 3) != 0;
            if (n == RANDOM_ITEMS / 2)
                wait_until_drained();
            calm = (n + CALM_ITEMS >= RANDOM_ITEMS);
            send_random(mode, counted);
            if (counted)
                n++;
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
